@@ sv/wildcard_pattern_matcher_core_defines.svh @@
`ifndef WILDCARD_PATTERN_MATCHER_CORE_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk and held off while in reset.
`define WPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and held off while in reset.
`define WPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/wpm_pkg.sv @@
`default_nettype none

package wpm_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int POS_COUNT   = PATTERN_MAX + 1;
    localparam int LEN_W       = $clog2(POS_COUNT);
    localparam int CHAR_W      = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CHAR_W-1:0] WILD_ONE = 8'h25;
    localparam logic [CHAR_W-1:0] WILD_ANY = 8'h2A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2
    } cfg_reg_t;

    // Signals that one cell hands to the cell at the next pattern position.
    typedef struct packed {
        logic pre_carry;
        logic adv;
        logic post_carry;
    } wpm_link_t;

endpackage

`default_nettype wire

@@ sv/wpm_cell.sv @@
`default_nettype none

module wpm_cell
    import wpm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              head,
    input  wire logic              advance,
    input  wire logic              restart,
    input  wire logic [CHAR_W-1:0] pat_char,
    input  wire logic              in_pat,
    input  wire logic              in_range,
    input  wire logic [CHAR_W-1:0] char_byte,
    input  wire logic              no_char,
    input  wire wpm_link_t         link_in,
    output wpm_link_t              link_out,
    output logic                   s_bit,
    output logic                   act_bit
);

    logic act_reg;
    logic act_next;
    logic is_any;
    logic is_one;
    logic is_eq;
    logic star;
    logic pre;
    logic adv;
    logic nxt;
    logic post;

    assign is_any = (pat_char == WILD_ANY);
    assign is_one = (pat_char == WILD_ONE);
    assign is_eq  = (pat_char == char_byte);
    assign star   = in_pat & is_any;

    // Star closure of the stored set, then the step over one character,
    // then the star closure of the new set.
    assign pre  = (act_reg & in_range) | link_in.pre_carry;
    assign adv  = pre & in_pat & ~is_any & (is_one | is_eq);
    assign nxt  = (pre & star) | link_in.adv;
    assign post = nxt | link_in.post_carry;

    assign link_out.pre_carry  = pre & star;
    assign link_out.adv        = adv;
    assign link_out.post_carry = post & star;

    assign s_bit    = no_char ? pre : post;
    assign act_next = restart ? head : s_bit;
    assign act_bit  = act_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= head;
        end else if (advance) begin
            act_reg <= act_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/wpm_out_stage.sv @@
`default_nettype none

module wpm_out_stage
    import wpm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic load,
    input  wire logic matched_in,
    input  wire logic m_ready,
    output logic      m_valid,
    output logic      m_matched,
    output logic      space
);

    logic m_valid_reg;
    logic m_valid_next;
    logic m_matched_reg;

    assign space = ~m_valid_reg | m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_matched_reg <= matched_in;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_matched = m_matched_reg;

endmodule

`default_nettype wire

@@ sv/wildcard_pattern_matcher_core.sv @@
`default_nettype none
`include "wildcard_pattern_matcher_core_defines.svh"

// Streams a candidate string one character per item against a wildcard
// pattern of up to 16 characters, where '%' matches any one character, '*'
// matches any run including an empty one, and every other byte matches
// itself; after the item marked last, one result item tells whether the whole
// candidate matched. A new item is accepted in every cycle unless a final
// item is held back: a row of 17 cells, one per pattern position, holds the
// set of active positions and computes its update combinationally through
// the star carry chain that runs along the row. A final item is taken only
// when the one-entry result register is free or being emptied in that cycle.
// Pattern registers may be rewritten between strings or between items.
module wildcard_pattern_matcher_core
    import wpm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [CHAR_W-1:0]     s_char_byte,
    input  wire logic                  s_is_last,
    input  wire logic                  s_no_char,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_matched
);

    logic [CFG_DATA_W-1:0]          pat_low_reg;
    logic [CFG_DATA_W-1:0]          pat_high_reg;
    logic [LEN_W-1:0]               pat_len_reg;
    logic [LEN_W-1:0]               eff_len;
    logic [2*CFG_DATA_W-1:0]        pat_all;
    logic                           accept;
    logic                           restart;
    logic                           space;
    logic                           matched_next;
    logic [POS_COUNT-1:0]           s_vec;
    logic [POS_COUNT-1:0]           act_vec;
    wpm_link_t                      links [POS_COUNT+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PAT_LOW:  pat_low_reg  <= cfg_wdata;
                CFG_PAT_HIGH: pat_high_reg <= cfg_wdata;
                CFG_PAT_LEN:  pat_len_reg  <= cfg_wdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign eff_len = (pat_len_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_reg;
    assign pat_all = {pat_high_reg, pat_low_reg};

    assign s_ready = space | ~s_is_last;
    assign accept  = s_valid & s_ready;
    assign restart = s_is_last;

    assign links[0] = '0;

    for (genvar i = 0; i < POS_COUNT; i++) begin : g_cell
        logic [CHAR_W-1:0] cell_char;
        logic              cell_in_pat;

        if (i < PATTERN_MAX) begin : g_pat
            assign cell_char   = pat_all[CHAR_W*i +: CHAR_W];
            assign cell_in_pat = (LEN_W'(i) < eff_len);
        end else begin : g_tail
            assign cell_char   = '0;
            assign cell_in_pat = 1'b0;
        end

        wpm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .head      (i == 0),
            .advance   (accept),
            .restart   (restart),
            .pat_char  (cell_char),
            .in_pat    (cell_in_pat),
            .in_range  (LEN_W'(i) <= eff_len),
            .char_byte (s_char_byte),
            .no_char   (s_no_char),
            .link_in   (links[i]),
            .link_out  (links[i+1]),
            .s_bit     (s_vec[i]),
            .act_bit   (act_vec[i])
        );
    end

    assign matched_next = s_vec[eff_len];

    wpm_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept & s_is_last),
        .matched_in (matched_next),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_matched  (m_matched),
        .space      (space)
    );

    `WPM_ASSERT_NOW(a_ready_only_blocked_by_result, !s_ready, m_valid,
        "input stalled although the result register is free")
    `WPM_ASSERT_NEXT(a_last_gives_result, accept && s_is_last, m_valid,
        "final item accepted but no result item presented")
    `WPM_ASSERT_NEXT(a_last_restarts, accept && s_is_last,
        act_vec == POS_COUNT'(1), "active set not back at the start after a final item")
    `WPM_ASSERT_NEXT(a_idle_holds_set, !accept && !$past(cfg_wr_en),
        act_vec == $past(act_vec), "active set changed without an accepted item")

endmodule

`default_nettype wire
